>>> sv/btbr_pkg.sv
`timescale 1ns / 1ps

package btbr_pkg;

   // Geometry; set counts and table depths are powers of two
   localparam int PARTITIONS        = 9;
   localparam int SETS              = 512;
   localparam int LAST_SETS         = 64;
   localparam int RAS_DEPTH         = 64;
   localparam int CALL_SIZE_ENTRIES = 1024;

   localparam int SET_W   = $clog2(SETS);
   localparam int LAST_W  = $clog2(LAST_SETS);
   localparam int IDX_W   = (SET_W > LAST_W) ? SET_W : LAST_W;
   localparam int PART_W  = $clog2(PARTITIONS);
   localparam int RAS_W   = $clog2(RAS_DEPTH);
   localparam int CST_W   = $clog2(CALL_SIZE_ENTRIES);
   localparam int SETS_MAX = (SETS > LAST_SETS) ? SETS : LAST_SETS;
   localparam int CLR_LEN = (SETS_MAX > CALL_SIZE_ENTRIES) ? SETS_MAX : CALL_SIZE_ENTRIES;
   localparam int CLR_W   = $clog2(CLR_LEN);

   // Decoupling queue
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 2) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [63:0] FAR_AGE         = 64'd9999999999;
   localparam logic [63:0] MAX_CALL_SIZE   = 64'd10;
   localparam logic [3:0]  RESET_CALL_SIZE = 4'd4;
   localparam logic [7:0]  TAG_LOW_MASK    = 8'hFF;

   localparam logic FUNC_PREDICT = 1'b0;
   localparam logic FUNC_UPDATE  = 1'b1;

   typedef enum logic [2:0] {
      KIND_NONE, KIND_DJUMP, KIND_IJUMP, KIND_COND,
      KIND_DCALL, KIND_ICALL, KIND_RETURN, KIND_OTHER
   } kind_type;

   // Classified transaction handed from front to back
   typedef struct packed {
      logic              func;
      logic [63:0]       ip;
      kind_type          kind;
      logic [63:0]       target;
      logic              taken;
      logic [PART_W-1:0] start;
      logic [15:0]       tag_main;
      logic [15:0]       tag_last;
   } item_type;

   // One buffer entry
   typedef struct packed {
      logic        valid;
      logic [15:0] tag;
      logic [63:0] target;
      kind_type    kind;
      logic [63:0] age;
   } entry_type;

   typedef struct packed {
      logic               full;
      logic               empty;
      logic [Q_CNT_W-1:0] count;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Folded tag: low byte of the upper address, high byte the XOR of the rest
   function automatic logic [15:0] fold_tag(input logic [63:0] ip, input int bits);
      logic [63:0] a;
      logic [7:0]  hi;
      a  = (ip >> 2) >> bits;
      hi = '0;
      for (int i = 1; i < 8; i++) begin
         hi = hi ^ a[8*i +: 8];
      end
      return {hi, a[7:0] & TAG_LOW_MASK};
   endfunction

   // Offset class from the bit length of the address difference
   function automatic logic [PART_W-1:0] start_class(input logic [61:0] d);
      int c;
      c = 0;
      if (d != '0)      c = 1;
      if (|d[61:4])     c = 2;
      if (|d[61:5])     c = 3;
      if (|d[61:7])     c = 4;
      if (|d[61:9])     c = 5;
      if (|d[61:11])    c = 6;
      if (|d[61:19])    c = 7;
      if (|d[61:25])    c = 8;
      if (c > PARTITIONS - 1) c = PARTITIONS - 1;
      return PART_W'(c);
   endfunction

   function automatic logic [63:0] age_of(input entry_type e);
      return e.valid ? e.age : 64'd0;
   endfunction

endpackage

>>> sv/btbr_ram.sv
`timescale 1ns / 1ps

module btbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> sv/btbr_front.sv
`timescale 1ns / 1ps

module btbr_front import btbr_pkg::*; (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [135:0]     req_tdata,  // ip, kind, target, taken
   input  logic [0:0]       req_tuser,  // func
   input  queue_status_type q_status,
   input  back_status_type  b_status,
   output logic             push,
   output item_type         push_item
);

   logic [63:0] ip;
   logic [63:0] target;
   kind_type    kind;

   assign ip     = req_tdata[63:0];
   assign kind   = kind_type'(req_tdata[66:64]);
   assign target = req_tdata[130:67];

   // No transactions while the tables are being cleared
   assign req_tready = !q_status.full && !b_status.clearing;
   assign push       = req_tvalid && req_tready;

   // Classify: tags for both partition sizes and the offset class
   always_comb begin
      push_item.func     = req_tuser[0];
      push_item.ip       = ip;
      push_item.kind     = kind;
      push_item.target   = target;
      push_item.taken    = req_tdata[131];
      push_item.tag_main = fold_tag(ip, SET_W);
      push_item.tag_last = fold_tag(ip, LAST_W);
      if (kind == KIND_RETURN) begin
         push_item.start = '0;
      end else begin
         push_item.start = start_class(ip[63:2] ^ target[63:2]);
      end
   end

endmodule

>>> sv/btbr_queue.sv
`timescale 1ns / 1ps

module btbr_queue import btbr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         pop_item,
   output queue_status_type status
);

   item_type           mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wptr_ff;
   logic [Q_PTR_W-1:0] rptr_ff;
   logic [Q_CNT_W-1:0] count_ff;

   assign pop_item     = mem_ff[rptr_ff];
   assign status.count = count_ff;
   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> sv/btbr_back.sv
`timescale 1ns / 1ps

module btbr_back import btbr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   output logic             pop,
   input  item_type         pop_item,
   output back_status_type  status,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [71:0]      rsp_tdata
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RD_OWN, ST_RD_PREV, ST_RD_NEXT,
      ST_CAPTURE, ST_EVAL, ST_SCAN, ST_PLACE
   } state_type;

   typedef enum logic [1:0] {POS_OWN, POS_PREV, POS_NEXT} pos_type;

   state_type          state_ff;
   logic [CLR_W-1:0]   clr_ff;
   item_type           cur_ff;
   entry_type          own_ff  [PARTITIONS];
   entry_type          prev_ff [PARTITIONS];
   entry_type          next_ff [PARTITIONS];
   logic [63:0]        t_ff;
   logic [3:0]         cst_ff;
   logic [RAS_W-1:0]   top_ff;
   logic [RAS_DEPTH-1:0] ras_vld_ff;
   logic [63:0]        wc_ff;
   logic [63:0]        bc_ff, bp_ff, bn_ff;
   logic [PART_W-1:0]  cid_ff, pid_ff, nid_ff, scan_ff;
   logic               pid_ok_ff, nid_ok_ff;
   logic               rsp_vld_ff;
   logic [71:0]        rsp_data_ff;

   logic [IDX_W-1:0]   idx     [PARTITIONS];
   logic [15:0]        tag     [PARTITIONS];
   logic [PARTITIONS-1:0] prev_ok, next_ok;

   logic [PARTITIONS-1:0] ent_we;
   logic [IDX_W-1:0]   ent_waddr [PARTITIONS];
   entry_type          ent_wdata [PARTITIONS];
   logic [IDX_W-1:0]   ent_raddr [PARTITIONS];
   entry_type          ent_rdata [PARTITIONS];

   logic               ras_we;
   logic [RAS_W-1:0]   ras_waddr;
   logic [63:0]        ras_rdata;
   logic [63:0]        t_val;
   logic               cst_we;
   logic [CST_W-1:0]   cst_waddr;
   logic [3:0]         cst_wdata;
   logic [3:0]         cst_rdata;

   logic               hit;
   logic [PART_W-1:0]  hp;
   pos_type            hpos;
   entry_type          hent;
   logic [PART_W-1:0]  mp;
   pos_type            mpos;
   logic [63:0]        ret_gap;
   logic [RAS_W-1:0]   top_inc, top_dec;
   logic               rsp_load;
   logic               do_push;
   logic [63:0]        v_own, v_prev, v_next;

   function automatic logic [IDX_W-1:0] addr_of(input logic [IDX_W-1:0] i, input pos_type p);
      case (p)
         POS_PREV: return i - 1'b1;
         POS_NEXT: return i + 1'b1;
         default:  return i;
      endcase
   endfunction

   // Per-partition set index, tag and neighbor existence
   always_comb begin
      for (int p = 0; p < PARTITIONS; p++) begin
         if (p == PARTITIONS - 1) begin
            idx[p]     = IDX_W'(cur_ff.ip[2 +: LAST_W]);
            tag[p]     = cur_ff.tag_last;
            next_ok[p] = (idx[p] != IDX_W'(LAST_SETS - 1));
         end else begin
            idx[p]     = IDX_W'(cur_ff.ip[2 +: SET_W]);
            tag[p]     = cur_ff.tag_main;
            next_ok[p] = (idx[p] != IDX_W'(SETS - 1));
         end
         prev_ok[p] = (idx[p] != '0);
      end
   end

   // First match: lowest partition, own before previous before next
   always_comb begin
      hit  = 1'b0;
      hp   = '0;
      hpos = POS_OWN;
      hent = own_ff[0];
      for (int p = PARTITIONS - 1; p >= 0; p--) begin
         if (next_ok[p] && next_ff[p].valid && next_ff[p].tag == tag[p]) begin
            hit = 1'b1; hp = PART_W'(p); hpos = POS_NEXT; hent = next_ff[p];
         end
         if (prev_ok[p] && prev_ff[p].valid && prev_ff[p].tag == tag[p]) begin
            hit = 1'b1; hp = PART_W'(p); hpos = POS_PREV; hent = prev_ff[p];
         end
         if (own_ff[p].valid && own_ff[p].tag == tag[p]) begin
            hit = 1'b1; hp = PART_W'(p); hpos = POS_OWN; hent = own_ff[p];
         end
      end
   end

   // Placement choice from the age winners
   always_comb begin
      mp   = cid_ff;
      mpos = POS_OWN;
      if (pid_ok_ff && pid_ff < mp) begin
         mp = pid_ff; mpos = POS_PREV;
      end
      if (nid_ok_ff && nid_ff < mp) begin
         mp = nid_ff; mpos = POS_NEXT;
      end
   end

   // Ages of the partition under scan
   assign v_own  = age_of(own_ff[scan_ff]);
   assign v_prev = age_of(prev_ff[scan_ff]);
   assign v_next = age_of(next_ff[scan_ff]);

   assign ret_gap = (t_ff > cur_ff.target) ? t_ff - cur_ff.target : cur_ff.target - t_ff;
   assign top_inc = (top_ff == RAS_W'(RAS_DEPTH - 1)) ? '0 : top_ff + 1'b1;
   assign top_dec = (top_ff == '0) ? RAS_W'(RAS_DEPTH - 1) : top_ff - 1'b1;
   assign t_val   = ras_vld_ff[top_ff] ? ras_rdata : 64'd0;

   assign rsp_load = (state_ff == ST_EVAL) && (cur_ff.func == FUNC_PREDICT) &&
                     (!rsp_vld_ff || rsp_tready);
   assign do_push  = rsp_load && (hit ? (hent.kind == KIND_DCALL || hent.kind == KIND_ICALL)
                                      : (cur_ff.kind == KIND_DCALL || cur_ff.kind == KIND_ICALL));

   assign pop        = (state_ff == ST_IDLE) && !q_status.empty;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Entry memory ports
   always_comb begin
      for (int p = 0; p < PARTITIONS; p++) begin
         case (state_ff)
            ST_RD_PREV: ent_raddr[p] = addr_of(idx[p], POS_PREV);
            ST_RD_NEXT: ent_raddr[p] = addr_of(idx[p], POS_NEXT);
            default:    ent_raddr[p] = idx[p];
         endcase
         ent_we[p]    = 1'b0;
         ent_waddr[p] = idx[p];
         ent_wdata[p] = hent;
         if (state_ff == ST_CLEAR) begin
            ent_we[p]    = 1'b1;
            ent_waddr[p] = clr_ff[IDX_W-1:0];
            ent_wdata[p] = '0;
         end else if (state_ff == ST_EVAL && cur_ff.func == FUNC_UPDATE && cur_ff.taken &&
                      hit && hp == PART_W'(p)) begin
            ent_we[p]           = 1'b1;
            ent_waddr[p]        = addr_of(idx[p], hpos);
            ent_wdata[p].kind   = cur_ff.kind;
            ent_wdata[p].age    = wc_ff;
            if (cur_ff.target != '0) ent_wdata[p].target = cur_ff.target;
         end else if (state_ff == ST_PLACE && mp == PART_W'(p) && cur_ff.target != '0) begin
            ent_we[p]           = 1'b1;
            ent_waddr[p]        = addr_of(idx[p], mpos);
            ent_wdata[p].valid  = 1'b1;
            ent_wdata[p].tag    = tag[p];
            ent_wdata[p].target = cur_ff.target;
            ent_wdata[p].kind   = cur_ff.kind;
            ent_wdata[p].age    = wc_ff;
         end
      end
   end

   // Return stack and call size ports
   always_comb begin
      ras_we    = do_push;
      ras_waddr = top_inc;
      cst_we    = 1'b0;
      cst_waddr = t_ff[CST_W-1:0];
      cst_wdata = ret_gap[3:0];
      if (state_ff == ST_CLEAR) begin
         cst_we    = 1'b1;
         cst_waddr = clr_ff[CST_W-1:0];
         cst_wdata = RESET_CALL_SIZE;
      end else if (state_ff == ST_EVAL && cur_ff.func == FUNC_UPDATE &&
                   cur_ff.kind == KIND_RETURN && ret_gap <= MAX_CALL_SIZE) begin
         cst_we = 1'b1;
      end
   end

   for (genvar g = 0; g < PARTITIONS; g++) begin : g_part
      localparam int DEP = (g == PARTITIONS - 1) ? LAST_SETS : SETS;
      localparam int AW  = $clog2(DEP);
      btbr_ram #(.WIDTH($bits(entry_type)), .DEPTH(DEP)) u_ram (
         .clock (clock),
         .we    (ent_we[g]),
         .waddr (ent_waddr[g][AW-1:0]),
         .wdata (ent_wdata[g]),
         .raddr (ent_raddr[g][AW-1:0]),
         .rdata (ent_rdata[g])
      );
   end

   btbr_ram #(.WIDTH(64), .DEPTH(RAS_DEPTH)) u_ras (
      .clock (clock),
      .we    (ras_we),
      .waddr (ras_waddr),
      .wdata (cur_ff.ip),
      .raddr (top_ff),
      .rdata (ras_rdata)
   );

   btbr_ram #(.WIDTH(4), .DEPTH(CALL_SIZE_ENTRIES)) u_cst (
      .clock (clock),
      .we    (cst_we),
      .waddr (cst_waddr),
      .wdata (cst_wdata),
      .raddr (t_val[CST_W-1:0]),
      .rdata (cst_rdata)
   );

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         top_ff     <= '0;
         ras_vld_ff <= '0;
         wc_ff      <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_vld_ff <= 1'b1;
         else if (rsp_tready) rsp_vld_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_W'(CLR_LEN - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (pop) begin
                  cur_ff   <= pop_item;
                  state_ff <= ST_RD_OWN;
               end
            end
            ST_RD_OWN: state_ff <= ST_RD_PREV;
            ST_RD_PREV: begin
               own_ff   <= ent_rdata;
               t_ff     <= t_val;
               state_ff <= ST_RD_NEXT;
            end
            ST_RD_NEXT: begin
               prev_ff  <= ent_rdata;
               cst_ff   <= cst_rdata;
               state_ff <= ST_CAPTURE;
            end
            ST_CAPTURE: begin
               next_ff  <= ent_rdata;
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (cur_ff.func == FUNC_PREDICT) begin
                  if (rsp_load) begin
                     if (!hit) begin
                        rsp_data_ff <= {4'd0, KIND_COND, 64'd0, 1'b0};
                     end else if (hent.kind == KIND_RETURN) begin
                        rsp_data_ff <= {4'd0, KIND_RETURN, t_ff + 64'(cst_ff), 1'b1};
                     end else begin
                        rsp_data_ff <= {4'd0, hent.kind, hent.target, 1'b1};
                     end
                     if (do_push) begin
                        top_ff             <= top_inc;
                        ras_vld_ff[top_inc] <= 1'b1;
                     end
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  if (cur_ff.kind == KIND_RETURN) begin
                     ras_vld_ff[top_ff] <= 1'b0;
                     top_ff             <= top_dec;
                  end
                  if (!cur_ff.taken) begin
                     state_ff <= ST_IDLE;
                  end else if (hit) begin
                     wc_ff    <= wc_ff + 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     bc_ff     <= age_of(own_ff[cur_ff.start]);
                     bp_ff     <= prev_ok[cur_ff.start] ? age_of(prev_ff[cur_ff.start]) : FAR_AGE;
                     bn_ff     <= next_ok[cur_ff.start] ? age_of(next_ff[cur_ff.start]) : FAR_AGE;
                     cid_ff    <= cur_ff.start;
                     pid_ok_ff <= 1'b0;
                     nid_ok_ff <= 1'b0;
                     scan_ff   <= cur_ff.start + 1'b1;
                     if (cur_ff.start == PART_W'(PARTITIONS - 1)) state_ff <= ST_PLACE;
                     else state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (v_own < bc_ff) begin
                  bc_ff  <= v_own;
                  cid_ff <= scan_ff;
               end
               if (prev_ok[scan_ff] && v_prev < bp_ff) begin
                  bp_ff     <= v_prev;
                  pid_ff    <= scan_ff;
                  pid_ok_ff <= 1'b1;
               end
               if (next_ok[scan_ff] && v_next < bn_ff) begin
                  bn_ff     <= v_next;
                  nid_ff    <= scan_ff;
                  nid_ok_ff <= 1'b1;
               end
               scan_ff <= scan_ff + 1'b1;
               if (scan_ff == PART_W'(PARTITIONS - 1)) state_ff <= ST_PLACE;
            end
            ST_PLACE: begin
               wc_ff    <= wc_ff + 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> sv/partitioned_offset_btb_with_ras.sv
`timescale 1ns / 1ps
// Partitioned branch target buffer with return address stack.
// Request channel (req_*): one transaction per branch. tuser carries func
// (0 predict, 1 resolved update); tdata carries ip, kind, target, taken.
// Response channel (rsp_*): one transaction per predict, none per update;
// tdata carries hit, predicted_target, predicted_type.
// A front stage classifies each request (tags, offset class) into a two-entry
// queue; a back sequencer reads the own, previous and next set of all nine
// partition memories one set position per cycle, then decides.
// After the reads the sequencer evaluates; a predict responds from the evaluate
// state, and a taken update that misses then scans each partition above the
// offset class and places the entry. Transactions are handled one at a time;
// the set reads go through the single read port of each partition memory in
// turn.
// Reset: a clearing pass sweeps all entries of the entry and call size
// memories; req_tready stays low during it.
// A stalled response is held in an output register; the next request is still
// accepted into the queue, and the back end waits only when a second predict
// is ready to respond.
module partitioned_offset_btb_with_ras import btbr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // ip[63:0], kind[66:64], target[130:67], taken[131]
   input  logic [0:0]   req_tuser,  // func[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata   // hit[0], predicted_target[64:1], predicted_type[67:65]
);

   queue_status_type q_status;
   back_status_type  b_status;
   logic             push, pop;
   item_type         push_item, pop_item;

   btbr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .b_status   (b_status),
      .push       (push),
      .push_item  (push_item)
   );

   btbr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   btbr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop        (pop),
      .pop_item   (pop_item),
      .status     (b_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // No request taken while the memories are being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      b_status.clearing |-> !req_tready)
      else $error("request accepted during clearing pass");

   // Queue fill never exceeds its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= Q_CNT_W'(Q_DEPTH))
      else $error("queue overfilled");

   // Back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");
`endif

endmodule
